/* design/hs1_pkg.sv */
`default_nettype none
package hs1_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       last_item;
  } item_t;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [4:0][31:0]  dig_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic FUNC_KEY = 1'b0;
  localparam logic FUNC_MSG = 1'b1;

  localparam dig_t SHA_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                             32'hefcdab89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage
`default_nettype wire

/* design/hs1_front.sv */
`default_nettype none
module hs1_front #(
  parameter int Depth = hs1_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hs1_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_pop,
  output hs1_pkg::item_t     q_item
);
  import hs1_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t          mem [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;

  assign in_stall = (count == CW'(Depth));
  assign q_valid  = (count != '0);
  assign push     = in_valid && !in_stall;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(q_pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(Depth)) else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1) else $error("queue count slip");
`endif

endmodule
`default_nettype wire

/* design/hs1_compress.sv */
`default_nettype none
module hs1_compress (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire hs1_pkg::blk_t blk,
  input  wire hs1_pkg::dig_t chain_in,
  output logic               busy,
  output logic               done,
  output hs1_pkg::dig_t      hash_out
);
  import hs1_pkg::*;

  blk_t        w;
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [31:0] f, k, t, wnew;

  always_comb begin
    if (rnd < 7'd20) begin
      f = ((c ^ d) & b) ^ d;
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + w[0] + k;
    wnew = w[13] ^ w[8] ^ w[2] ^ w[0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w <= blk;
      a <= chain_in[0];
      b <= chain_in[1];
      c <= chain_in[2];
      d <= chain_in[3];
      e <= chain_in[4];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= {wnew[30:0], wnew[31]};
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      if (rnd == 7'd79) begin
        hash_out[0] <= chain_in[0] + t;
        hash_out[1] <= chain_in[1] + a;
        hash_out[2] <= chain_in[2] + {b[1:0], b[31:2]};
        hash_out[3] <= chain_in[3] + c;
        hash_out[4] <= chain_in[4] + d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == 7'd79) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("start while busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("done without rounds");
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> rnd < 7'd80) else $error("round count out of range");
`endif

endmodule
`default_nettype wire

/* design/hs1_core.sv */
`default_nettype none
module hs1_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire hs1_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [31:0]         mac_word,
  output logic [2:0]          word_index,
  output logic                last_word
);
  import hs1_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_K0    = 5'd1;
  localparam logic [4:0] S_K1    = 5'd2;
  localparam logic [4:0] S_KBYTE = 5'd3;
  localparam logic [4:0] S_K2    = 5'd4;
  localparam logic [4:0] S_KEND  = 5'd5;
  localparam logic [4:0] S_M0    = 5'd6;
  localparam logic [4:0] S_M1    = 5'd7;
  localparam logic [4:0] S_M2    = 5'd8;
  localparam logic [4:0] S_M3    = 5'd9;
  localparam logic [4:0] S_M4    = 5'd10;
  localparam logic [4:0] S_M5    = 5'd11;
  localparam logic [4:0] S_M7    = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;
  localparam logic [4:0] S_PUSH  = 5'd14;
  localparam logic [4:0] S_KICK  = 5'd15;
  localparam logic [4:0] S_WAIT  = 5'd16;
  localparam logic [4:0] S_KB    = 5'd17;
  localparam logic [4:0] S_F80   = 5'd18;
  localparam logic [4:0] S_FZ    = 5'd19;
  localparam logic [4:0] S_FL    = 5'd20;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_KEY     = 2'd1;
  localparam logic [1:0] PH_LONGKEY = 2'd2;
  localparam logic [1:0] PH_MSG     = 2'd3;

  logic [4:0]   state;
  logic [4:0]   ret;
  logic [4:0]   fret;
  logic [4:0]   kret;
  logic [1:0]   phase;
  item_t        item;
  blk_t         sched;
  blk_t         pk;
  dig_t         chain;
  logic [159:0] inner;
  logic [5:0]   bcnt;
  logic [63:0]  bitlen;
  logic [63:0]  lenreg;
  logic [6:0]   kcnt;
  logic [7:0]   pbyte;
  logic [7:0]   kpad;
  logic [4:0]   icnt;
  logic [3:0]   jcnt;
  logic [2:0]   oi;
  logic         comp_start;
  logic         comp_busy;
  logic         comp_done;
  dig_t         hash_out;

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign comp_start = (state == S_KICK);
  assign mac_word   = chain[oi];
  assign word_index = oi;
  assign last_word  = (oi == 3'd4);

  hs1_compress u_comp (
    .clk      (clk),
    .rst      (rst),
    .start    (comp_start),
    .blk      (sched),
    .chain_in (chain),
    .busy     (comp_busy),
    .done     (comp_done),
    .hash_out (hash_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      kcnt      <= '0;
      pk        <= '0;
      chain     <= SHA_IV;
      bcnt      <= '0;
      bitlen    <= '0;
      out_valid <= 1'b0;
      oi        <= '0;
      ret       <= S_IDLE;
      fret      <= S_IDLE;
      kret      <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            state <= (q_item.func == FUNC_MSG) ? S_M0 : S_K0;
          end
        end
        S_K0: begin
          if (phase != PH_KEY && phase != PH_LONGKEY) begin
            pk    <= '0;
            kcnt  <= '0;
            phase <= PH_KEY;
          end
          state <= S_K1;
        end
        S_K1: begin
          if (!item.carries_byte) begin
            state <= S_K2;
          end else if (phase == PH_KEY && kcnt < 7'd64) begin
            pk[kcnt[5:2]] <= pk[kcnt[5:2]] |
                             ({24'b0, item.data_byte} << {~kcnt[1:0], 3'b000});
            kcnt  <= kcnt + 1'b1;
            state <= S_K2;
          end else if (phase == PH_KEY) begin
            phase <= PH_LONGKEY;
            kcnt  <= 7'd65;
            kpad  <= 8'h00;
            kret  <= S_KBYTE;
            state <= S_KB;
          end else begin
            state <= S_KBYTE;
          end
        end
        S_KBYTE: begin
          pbyte  <= item.data_byte;
          bitlen <= bitlen + 64'd8;
          ret    <= S_K2;
          state  <= S_PUSH;
        end
        S_K2: begin
          if (item.last_item && phase == PH_LONGKEY) begin
            fret  <= S_KEND;
            state <= S_F80;
          end else begin
            if (item.last_item) begin
              phase <= PH_IDLE;
            end
            state <= S_IDLE;
          end
        end
        S_KEND: begin
          for (int i = 0; i < 5; i++) begin
            pk[i] <= chain[i];
          end
          for (int i = 5; i < 16; i++) begin
            pk[i] <= '0;
          end
          kcnt  <= 7'd20;
          phase <= PH_IDLE;
          state <= (item.func == FUNC_MSG) ? S_M1 : S_IDLE;
        end
        S_M0: begin
          if (phase == PH_LONGKEY) begin
            fret  <= S_KEND;
            state <= S_F80;
          end else begin
            if (phase == PH_KEY) begin
              phase <= PH_IDLE;
            end
            state <= S_M1;
          end
        end
        S_M1: begin
          if (phase != PH_MSG) begin
            phase <= PH_MSG;
            kpad  <= IPAD;
            kret  <= S_M2;
            state <= S_KB;
          end else begin
            state <= S_M2;
          end
        end
        S_M2: begin
          if (item.carries_byte) begin
            pbyte  <= item.data_byte;
            bitlen <= bitlen + 64'd8;
            ret    <= S_M3;
            state  <= S_PUSH;
          end else begin
            state <= S_M3;
          end
        end
        S_M3: begin
          if (item.last_item) begin
            fret  <= S_M4;
            state <= S_F80;
          end else begin
            state <= S_IDLE;
          end
        end
        S_M4: begin
          inner <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
          kpad  <= OPAD;
          kret  <= S_M5;
          icnt  <= '0;
          state <= S_KB;
        end
        S_M5: begin
          if (icnt == 5'd20) begin
            fret  <= S_M7;
            state <= S_F80;
          end else begin
            pbyte  <= inner[159:152];
            inner  <= {inner[151:0], 8'h00};
            bitlen <= bitlen + 64'd8;
            icnt   <= icnt + 1'b1;
            ret    <= S_M5;
            state  <= S_PUSH;
          end
        end
        S_M7: begin
          phase     <= PH_IDLE;
          oi        <= '0;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (oi == 3'd4) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              oi <= oi + 1'b1;
            end
          end
        end
        S_PUSH: begin
          sched[bcnt[5:2]] <= {sched[bcnt[5:2]][23:0], pbyte};
          bcnt             <= bcnt + 1'b1;
          state            <= (bcnt == 6'd63) ? S_KICK : ret;
        end
        S_KICK: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (comp_done) begin
            chain <= hash_out;
            state <= ret;
          end
        end
        S_KB: begin
          chain <= SHA_IV;
          for (int i = 0; i < 16; i++) begin
            sched[i] <= pk[i] ^ {4{kpad}};
          end
          bcnt   <= '0;
          bitlen <= 64'd512;
          ret    <= kret;
          state  <= S_KICK;
        end
        S_F80: begin
          lenreg <= bitlen;
          pbyte  <= PAD_MARK;
          ret    <= S_FZ;
          state  <= S_PUSH;
        end
        S_FZ: begin
          if (bcnt == 6'd56) begin
            jcnt  <= '0;
            state <= S_FL;
          end else begin
            pbyte <= 8'h00;
            ret   <= S_FZ;
            state <= S_PUSH;
          end
        end
        S_FL: begin
          if (jcnt == 4'd8) begin
            state <= fret;
          end else begin
            pbyte  <= lenreg[63:56];
            lenreg <= {lenreg[55:0], 8'h00};
            jcnt   <= jcnt + 1'b1;
            ret    <= S_FL;
            state  <= S_PUSH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_busy_wait: assert property (@(posedge clk) disable iff (rst)
    comp_busy |-> state == S_WAIT) else $error("compression outside wait");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_K0 || state == S_M0) else $error("pop not dispatched");
`endif

endmodule
`default_nettype wire

/* design/hmac_sha1_stream.sv */
`default_nettype none
// channel | handshake            | payload
// input   | in_valid / in_stall   | func, data_byte, carries_byte, last_item
// output  | out_valid / out_stall | mac_word, word_index, last_word
//
// Items enter a small queue and are taken one at a time by the sequencer.
// A stored key byte is written into the key block; a message byte or hashed key byte is pushed into the block buffer.
// Every 64 bytes start a SHA-1 compression; a message start first compresses the key block.
// A message end costs padding, one key block and the outer hash.
// The five words leave one per cycle while out_stall is low.
// Reset is synchronous and clears the key to empty.
module hmac_sha1_stream #(
  parameter int QueueDepth = hs1_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [7:0]  data_byte,
  input  wire logic        carries_byte,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      mac_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  import hs1_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign in_item = '{func: func, data_byte: data_byte,
                     carries_byte: carries_byte, last_item: last_item};

  hs1_front #(.Depth(QueueDepth)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  hs1_core u_core (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mac_word   (mac_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule
`default_nettype wire
